### hdl/sdd_pkg.sv
package sdd_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int unsigned VALUE_FIELD_BITS = 8;
   localparam int unsigned STATUS_BITS      = 3;
   localparam int unsigned COUNT_OUT_BITS   = 4;

   // Default sizes of the two sets and of the compared value.
   localparam int unsigned DEF_EXCL_DEPTH = 8;
   localparam int unsigned DEF_KEEP_DEPTH = 8;
   localparam int unsigned DEF_VALUE_BITS = 8;

   // Request commands.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   // Outcome codes reported with every response.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_KEPT      = 3'd0,
      ST_EXCLUDED  = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_DROPPED   = 3'd3,
      ST_LOADED    = 3'd4,
      ST_EXCL_FULL = 3'd5
   } status_type;

   typedef struct packed {
      logic                        cmd;
      logic [VALUE_FIELD_BITS-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]      status;
      logic [VALUE_FIELD_BITS-1:0] echo_value;
      logic [COUNT_OUT_BITS-1:0]   kept_count;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // take the request transaction
      logic scan;      // read one entry of each store
      logic commit;    // update the sets and load the response register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_test;  // command bit of the pending request
      logic scan_last;    // the current read is the last one needed
      logic out_free;     // the response register can take a new result
   } dp_status_type;

endpackage

### hdl/sdd_stream_if.sv
interface sdd_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

### hdl/set_difference_dedup.sv
// Set difference without duplicates. The block holds an exclusion set and a
// result set, both empty after reset. A load transaction appends its value to
// the exclusion set (status loaded, or exclusion full when no room is left).
// A test transaction reports excluded when the value is in the exclusion set,
// duplicate when it is already in the result set, dropped when the result set
// is full, and otherwise appends it to the result set and reports kept. Every
// request transaction yields exactly one response carrying the status, the
// value and the result set fill count. One request is handled at a time. A
// load goes from the idle state straight to the finish state. A test first
// passes through the scan and drain states; the scan length is the larger
// fill count, and the serial scan reads one entry of each store per cycle
// through the store's single read port. In the finish state the result is
// committed to the response register once that register is free, and only
// then is the next request accepted. The response register lets a new
// request be accepted while the previous response is still held.
module set_difference_dedup
   import sdd_pkg::*;
#(
   parameter int unsigned EXCL_DEPTH = DEF_EXCL_DEPTH,
   parameter int unsigned KEEP_DEPTH = DEF_KEEP_DEPTH,
   parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic         clock,
   input  logic         reset,
   sdd_stream_if.sink   req_chan,
   sdd_stream_if.source rsp_chan
);

   ctrl_cmd_type    ctrl_cmd;
   dp_status_type   dp_status;
   logic            req_ready;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;
   req_payload_type req_payload;

   assign req_payload = req_chan.payload;

   sdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   sdd_datapath #(
      .EXCL_DEPTH (EXCL_DEPTH),
      .KEEP_DEPTH (KEEP_DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctrl_cmd    (ctrl_cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

endmodule

### hdl/sdd_ctrl.sv
module sdd_ctrl
   import sdd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  ctrl_cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state: loads skip the scan, tests sweep both stores first.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = dp_status.req_is_test ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (dp_status.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands to the datapath.
   assign req_ready        = (state_ff == S_IDLE);
   assign ctrl_cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign ctrl_cmd.scan    = (state_ff == S_SCAN);
   assign ctrl_cmd.commit  = (state_ff == S_FINISH) && dp_status.out_free;

endmodule

### hdl/sdd_datapath.sv
module sdd_datapath
   import sdd_pkg::*;
#(
   parameter int unsigned EXCL_DEPTH = DEF_EXCL_DEPTH,
   parameter int unsigned KEEP_DEPTH = DEF_KEEP_DEPTH,
   parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  ctrl_cmd_type    ctrl_cmd,
   output dp_status_type   dp_status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   // Only the low bits of the value field take part.
   localparam int unsigned STORE_BITS =
      (VALUE_BITS < VALUE_FIELD_BITS) ? VALUE_BITS : VALUE_FIELD_BITS;
   localparam int unsigned EXCL_ADDR_BITS = (EXCL_DEPTH > 1) ? $clog2(EXCL_DEPTH) : 1;
   localparam int unsigned KEEP_ADDR_BITS = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
   localparam int unsigned EXCL_CNT_BITS  = $clog2(EXCL_DEPTH + 1);
   localparam int unsigned KEEP_CNT_BITS  = $clog2(KEEP_DEPTH + 1);
   localparam int unsigned MAX_DEPTH      = (EXCL_DEPTH > KEEP_DEPTH) ? EXCL_DEPTH : KEEP_DEPTH;
   localparam int unsigned SCAN_BITS      = $clog2(MAX_DEPTH + 1);

   // Set storage.
   logic [STORE_BITS-1:0] excl_mem [EXCL_DEPTH];
   logic [STORE_BITS-1:0] keep_mem [KEEP_DEPTH];

   logic                     cmd_ff;
   logic [STORE_BITS-1:0]    value_ff;
   logic [SCAN_BITS-1:0]     idx_ff;
   logic [SCAN_BITS-1:0]     idx_in;
   logic [STORE_BITS-1:0]    excl_rd_ff;
   logic [STORE_BITS-1:0]    keep_rd_ff;
   logic                     excl_cmp_ff;
   logic                     excl_cmp_in;
   logic                     keep_cmp_ff;
   logic                     keep_cmp_in;
   logic                     excl_hit_ff;
   logic                     excl_hit_in;
   logic                     keep_hit_ff;
   logic                     keep_hit_in;
   logic [EXCL_CNT_BITS-1:0] excl_cnt_ff;
   logic [EXCL_CNT_BITS-1:0] excl_cnt_in;
   logic [KEEP_CNT_BITS-1:0] keep_cnt_ff;
   logic [KEEP_CNT_BITS-1:0] keep_cnt_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_payload_type          rsp_payload_ff;
   rsp_payload_type          rsp_payload_in;

   logic [SCAN_BITS-1:0]     scan_len;
   logic [SCAN_BITS:0]       idx_next;
   logic                     excl_full;
   logic                     keep_full;
   logic                     excl_we;
   logic                     keep_we;
   status_type               status;
   logic [COUNT_OUT_BITS+KEEP_CNT_BITS-1:0] keep_cnt_ext;

   // Scan length is the larger of the two fill counts.
   always_comb begin
      if (SCAN_BITS'(excl_cnt_ff) > SCAN_BITS'(keep_cnt_ff)) begin
         scan_len = SCAN_BITS'(excl_cnt_ff);
      end else begin
         scan_len = SCAN_BITS'(keep_cnt_ff);
      end
   end

   assign idx_next  = {1'b0, idx_ff} + (SCAN_BITS + 1)'(1);
   assign excl_full = (excl_cnt_ff == EXCL_CNT_BITS'(EXCL_DEPTH));
   assign keep_full = (keep_cnt_ff == KEEP_CNT_BITS'(KEEP_DEPTH));

   // Scan index and compare qualifiers; only entries below a count are valid.
   always_comb begin
      idx_in      = idx_ff;
      excl_cmp_in = 1'b0;
      keep_cmp_in = 1'b0;
      if (ctrl_cmd.capture) begin
         idx_in = '0;
      end else if (ctrl_cmd.scan) begin
         idx_in      = idx_next[SCAN_BITS-1:0];
         excl_cmp_in = (idx_ff < SCAN_BITS'(excl_cnt_ff));
         keep_cmp_in = (idx_ff < SCAN_BITS'(keep_cnt_ff));
      end
   end

   // Hit flags gather matches one entry per cycle.
   always_comb begin
      excl_hit_in = excl_hit_ff;
      keep_hit_in = keep_hit_ff;
      if (ctrl_cmd.capture) begin
         excl_hit_in = 1'b0;
         keep_hit_in = 1'b0;
      end else begin
         if (excl_cmp_ff && (excl_rd_ff == value_ff)) begin
            excl_hit_in = 1'b1;
         end
         if (keep_cmp_ff && (keep_rd_ff == value_ff)) begin
            keep_hit_in = 1'b1;
         end
      end
   end

   // Outcome of the transaction, in priority order.
   always_comb begin
      priority if (cmd_ff == CMD_LOAD) begin
         status = excl_full ? ST_EXCL_FULL : ST_LOADED;
      end else if (excl_hit_ff) begin
         status = ST_EXCLUDED;
      end else if (keep_hit_ff) begin
         status = ST_DUPLICATE;
      end else if (keep_full) begin
         status = ST_DROPPED;
      end else begin
         status = ST_KEPT;
      end
   end

   assign excl_we = ctrl_cmd.commit && (status == ST_LOADED);
   assign keep_we = ctrl_cmd.commit && (status == ST_KEPT);

   // Fill counts and the response register.
   always_comb begin
      excl_cnt_in    = excl_cnt_ff + EXCL_CNT_BITS'(excl_we);
      keep_cnt_in    = keep_cnt_ff + KEEP_CNT_BITS'(keep_we);
      keep_cnt_ext   = {COUNT_OUT_BITS'(0), keep_cnt_in};
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (ctrl_cmd.commit) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.status     = status;
         rsp_payload_in.echo_value = VALUE_FIELD_BITS'(value_ff);
         rsp_payload_in.kept_count = keep_cnt_ext[COUNT_OUT_BITS-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         excl_cnt_ff  <= '0;
         keep_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         excl_cmp_ff  <= 1'b0;
         keep_cmp_ff  <= 1'b0;
      end else begin
         excl_cnt_ff  <= excl_cnt_in;
         keep_cnt_ff  <= keep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         excl_cmp_ff  <= excl_cmp_in;
         keep_cmp_ff  <= keep_cmp_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         cmd_ff   <= req_payload.cmd;
         value_ff <= req_payload.value[STORE_BITS-1:0];
      end
      idx_ff         <= idx_in;
      excl_hit_ff    <= excl_hit_in;
      keep_hit_ff    <= keep_hit_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Exclusion store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (excl_we) begin
         excl_mem[excl_cnt_ff[EXCL_ADDR_BITS-1:0]] <= value_ff;
      end
      excl_rd_ff <= excl_mem[idx_ff[EXCL_ADDR_BITS-1:0]];
   end

   // Result store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (keep_we) begin
         keep_mem[keep_cnt_ff[KEEP_ADDR_BITS-1:0]] <= value_ff;
      end
      keep_rd_ff <= keep_mem[idx_ff[KEEP_ADDR_BITS-1:0]];
   end

   assign dp_status.req_is_test = (req_payload.cmd == CMD_TEST);
   assign dp_status.scan_last   = (idx_next >= {1'b0, scan_len});
   assign dp_status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
